>>> design/cpt_pkg.sv
package cpt_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int MUL_STAGES = 5;
   localparam int FRONT_LAT = 5 + 2 * MUL_STAGES;

   typedef enum logic [2:0] {
      REG_A     = 3'd0,
      REG_B     = 3'd1,
      REG_AB    = 3'd2,
      REG_C     = 3'd3,
      REG_AC    = 3'd4,
      REG_BC    = 3'd5,
      REG_FACE  = 3'd6,
      REG_DEGEN = 3'd7
   } region_type;

endpackage

>>> design/cpt_req_if.sv
interface cpt_req_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic signed [W-1:0] point_x;
   logic signed [W-1:0] point_y;
   logic signed [W-1:0] point_z;
   logic signed [W-1:0] vert_a_x;
   logic signed [W-1:0] vert_a_y;
   logic signed [W-1:0] vert_a_z;
   logic signed [W-1:0] vert_b_x;
   logic signed [W-1:0] vert_b_y;
   logic signed [W-1:0] vert_b_z;
   logic signed [W-1:0] vert_c_x;
   logic signed [W-1:0] vert_c_y;
   logic signed [W-1:0] vert_c_z;

   modport source (
      output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
      output vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
      input ready
   );
   modport sink (
      input valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
      input vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
      output ready
   );
endinterface

>>> design/cpt_rsp_if.sv
interface cpt_rsp_if #(parameter int W = 32);
   logic valid;
   logic ready;
   logic signed [W-1:0] near_x;
   logic signed [W-1:0] near_y;
   logic signed [W-1:0] near_z;
   logic [2:0] region;

   modport source (output valid, near_x, near_y, near_z, region, input ready);
   modport sink (input valid, near_x, near_y, near_z, region, output ready);
endinterface

>>> design/cpt_front.sv
module cpt_mul import cpt_pkg::*; #(
   parameter int AW = 8,
   parameter int BW = 8,
   parameter int NS = MUL_STAGES
) (
   input  logic clock,
   input  logic en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [AW+BW-1:0] p
);

   localparam int CW = (BW + NS - 1) / NS;
   localparam int XW = NS * CW;
   localparam int PW = AW + BW;

   logic signed [AW-1:0] a_ff [NS];
   logic signed [XW-1:0] b_ff [NS];
   logic signed [PW-1:0] acc_ff [NS];
   logic signed [XW-1:0] bx;

   assign bx = XW'(b);

   // one digit of b per stage, top digit signed
   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic signed [AW-1:0] a_in;
      logic signed [XW-1:0] b_in;
      logic signed [PW-1:0] acc_prev;
      logic signed [CW:0] dig;
      logic signed [AW+CW:0] part;
      if (s == 0) begin : g_first
         assign a_in = a;
         assign b_in = bx;
         assign acc_prev = '0;
      end else begin : g_next
         assign a_in = a_ff[s-1];
         assign b_in = b_ff[s-1];
         assign acc_prev = acc_ff[s-1];
      end
      always_comb begin
         dig = (s == NS - 1) ? {b_in[XW-1], b_in[s*CW +: CW]}
                             : {1'b0, b_in[s*CW +: CW]};
         part = a_in * dig;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[s] <= a_in;
            b_ff[s] <= b_in;
            acc_ff[s] <= acc_prev + (PW'(part) <<< (s * CW));
         end
      end
   end

   assign p = acc_ff[NS-1];

endmodule

module cpt_front import cpt_pkg::*; #(
   parameter int W = COORD_BITS_DEF
) (
   input  logic clock,
   input  logic en,
   input  logic signed [W-1:0] pt [3],
   input  logic signed [W-1:0] va [3],
   input  logic signed [W-1:0] vb [3],
   input  logic signed [W-1:0] vc [3],
   output logic signed [W+(2*(2*(W+1)+2)+1)+2:0] num_out [3],
   output logic signed [2*(2*(W+1)+2)+2:0] den_out [3],
   output logic signed [W-1:0] base_out [3],
   output region_type region_out
);

   localparam int D = W + 1;
   localparam int P = 2 * D;
   localparam int K = P + 2;
   localparam int T = K + 1;
   localparam int EN = K + 2;
   localparam int G = 2 * K + 1;
   localparam int FD = G + 2;
   localparam int FN = D + G + 2;
   localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
   localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

   typedef struct packed {
      logic [2:0][W-1:0] a;
      logic [2:0][W-1:0] b;
      logic [2:0][W-1:0] c;
      logic [2:0][D-1:0] e1;
      logic [2:0][D-1:0] e2;
      logic [2:0][D-1:0] e3;
   } geo_type;

   geo_type g1_ff, g2_ff, g3_ff;
   geo_type gd_ff [MUL_STAGES];
   geo_type g4;
   logic signed [D-1:0] qa1_ff [3];
   logic signed [D-1:0] qb1_ff [3];
   logic signed [D-1:0] qc1_ff [3];
   logic signed [P-1:0] pr2_ff [6][3];
   logic signed [K-1:0] k3_ff [6];
   logic signed [K-1:0] kd_ff [MUL_STAGES][6];
   logic signed [K-1:0] k4 [6];
   logic signed [2*K-1:0] mm [6];

   // stage 1: edges and offsets
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            g1_ff.a[i] <= va[i];
            g1_ff.b[i] <= vb[i];
            g1_ff.c[i] <= vc[i];
            g1_ff.e1[i] <= D'(vb[i]) - D'(va[i]);
            g1_ff.e2[i] <= D'(vc[i]) - D'(va[i]);
            g1_ff.e3[i] <= D'(vc[i]) - D'(vb[i]);
            qa1_ff[i] <= D'(pt[i]) - D'(va[i]);
            qb1_ff[i] <= D'(pt[i]) - D'(vb[i]);
            qc1_ff[i] <= D'(pt[i]) - D'(vc[i]);
         end
      end
   end

   // stage 2: dot product terms
   always_ff @(posedge clock) begin
      if (en) begin
         g2_ff <= g1_ff;
         for (int i = 0; i < 3; i++) begin
            pr2_ff[0][i] <= $signed(g1_ff.e1[i]) * qa1_ff[i];
            pr2_ff[1][i] <= $signed(g1_ff.e2[i]) * qa1_ff[i];
            pr2_ff[2][i] <= $signed(g1_ff.e1[i]) * qb1_ff[i];
            pr2_ff[3][i] <= $signed(g1_ff.e2[i]) * qb1_ff[i];
            pr2_ff[4][i] <= $signed(g1_ff.e1[i]) * qc1_ff[i];
            pr2_ff[5][i] <= $signed(g1_ff.e2[i]) * qc1_ff[i];
         end
      end
   end

   // stage 3: dot sums
   always_ff @(posedge clock) begin
      if (en) begin
         g3_ff <= g2_ff;
         for (int m = 0; m < 6; m++) begin
            k3_ff[m] <= K'(pr2_ff[m][0]) + K'(pr2_ff[m][1]) + K'(pr2_ff[m][2]);
         end
      end
   end

   // stage 4: cross terms of the dots
   for (genvar m = 0; m < 6; m++) begin : g_cross
      cpt_mul #(.AW(K), .BW(K), .NS(MUL_STAGES)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (k3_ff[MA[m]]),
         .b     (k3_ff[MB[m]]),
         .p     (mm[m])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gd_ff[0] <= g3_ff;
         kd_ff[0] <= k3_ff;
         for (int s = 1; s < MUL_STAGES; s++) begin
            gd_ff[s] <= gd_ff[s-1];
            kd_ff[s] <= kd_ff[s-1];
         end
      end
   end

   assign g4 = gd_ff[MUL_STAGES-1];
   assign k4 = kd_ff[MUL_STAGES-1];

   // stage 5: region decision
   logic signed [G-1:0] ga, gb, gc;
   logic signed [T-1:0] t1, t2;
   logic signed [EN-1:0] den_ab, den_ac, den_bc;
   logic signed [FD-1:0] den_face;
   region_type region_in;
   logic [1:0] base_sel;
   logic [1:0] dir_sel;
   logic signed [EN-1:0] ednum_in;
   logic signed [FD-1:0] den_in;

   always_comb begin
      gc = mm[0] - mm[1];
      gb = mm[2] - mm[3];
      ga = mm[4] - mm[5];
      t1 = k4[3] - k4[2];
      t2 = k4[4] - k4[5];
      den_ab = k4[0] - k4[2];
      den_ac = k4[1] - k4[5];
      den_bc = t1 + t2;
      den_face = ga + gb + gc;
      region_in = REG_FACE;
      base_sel = 2'd0;
      dir_sel = 2'd0;
      ednum_in = '0;
      den_in = den_face;
      if (k4[0] <= 0 && k4[1] <= 0) begin
         region_in = REG_A;
      end else if (k4[2] >= 0 && t1 <= 0) begin
         region_in = REG_B;
         base_sel = 2'd1;
      end else if (gc <= 0 && k4[0] >= 0 && k4[2] <= 0) begin
         region_in = REG_AB;
         ednum_in = k4[0];
         den_in = den_ab;
      end else if (k4[5] >= 0 && k4[4] - k4[5] <= 0) begin
         region_in = REG_C;
         base_sel = 2'd2;
      end else if (gb <= 0 && k4[1] >= 0 && k4[5] <= 0) begin
         region_in = REG_AC;
         dir_sel = 2'd1;
         ednum_in = k4[1];
         den_in = den_ac;
      end else if (ga <= 0 && t1 >= 0 && t2 >= 0) begin
         region_in = REG_BC;
         base_sel = 2'd1;
         dir_sel = 2'd2;
         ednum_in = t1;
         den_in = den_bc;
      end
      if (region_in != REG_A && region_in != REG_B && region_in != REG_C && den_in == 0) begin
         region_in = REG_DEGEN;
         base_sel = 2'd0;
      end
   end

   region_type reg5_ff, reg7_ff;
   region_type rd_ff [MUL_STAGES];
   logic signed [W-1:0] base5_ff [3];
   logic signed [W-1:0] bd_ff [MUL_STAGES][3];
   logic signed [W-1:0] base7_ff [3];
   logic signed [D-1:0] dir5_ff [3];
   logic signed [D-1:0] e1_5_ff [3];
   logic signed [D-1:0] e2_5_ff [3];
   logic signed [EN-1:0] ednum5_ff;
   logic signed [FD-1:0] den5_ff;
   logic signed [FD-1:0] dd_ff [MUL_STAGES];
   logic signed [G-1:0] gb5_ff, gc5_ff;
   logic signed [EN+D-1:0] pa6 [3];
   logic signed [G+D-1:0] pf1_6 [3];
   logic signed [G+D-1:0] pf2_6 [3];
   logic signed [FN-1:0] num7_ff [3];
   logic signed [FD-1:0] den7_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         reg5_ff <= region_in;
         ednum5_ff <= ednum_in;
         den5_ff <= den_in;
         gb5_ff <= gb;
         gc5_ff <= gc;
         for (int i = 0; i < 3; i++) begin
            e1_5_ff[i] <= $signed(g4.e1[i]);
            e2_5_ff[i] <= $signed(g4.e2[i]);
            case (base_sel)
               2'd1: base5_ff[i] <= $signed(g4.b[i]);
               2'd2: base5_ff[i] <= $signed(g4.c[i]);
               default: base5_ff[i] <= $signed(g4.a[i]);
            endcase
            case (dir_sel)
               2'd1: dir5_ff[i] <= $signed(g4.e2[i]);
               2'd2: dir5_ff[i] <= $signed(g4.e3[i]);
               default: dir5_ff[i] <= $signed(g4.e1[i]);
            endcase
         end
      end
   end

   // stage 6: numerator products
   for (genvar i = 0; i < 3; i++) begin : g_numer
      cpt_mul #(.AW(EN), .BW(D), .NS(MUL_STAGES)) u_pa (
         .clock (clock),
         .en    (en),
         .a     (ednum5_ff),
         .b     (dir5_ff[i]),
         .p     (pa6[i])
      );
      cpt_mul #(.AW(G), .BW(D), .NS(MUL_STAGES)) u_pf1 (
         .clock (clock),
         .en    (en),
         .a     (gb5_ff),
         .b     (e1_5_ff[i]),
         .p     (pf1_6[i])
      );
      cpt_mul #(.AW(G), .BW(D), .NS(MUL_STAGES)) u_pf2 (
         .clock (clock),
         .en    (en),
         .a     (gc5_ff),
         .b     (e2_5_ff[i]),
         .p     (pf2_6[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff[0] <= reg5_ff;
         dd_ff[0] <= den5_ff;
         bd_ff[0] <= base5_ff;
         for (int s = 1; s < MUL_STAGES; s++) begin
            rd_ff[s] <= rd_ff[s-1];
            dd_ff[s] <= dd_ff[s-1];
            bd_ff[s] <= bd_ff[s-1];
         end
      end
   end

   // stage 7: select numerator and divisor
   always_ff @(posedge clock) begin
      if (en) begin
         reg7_ff <= rd_ff[MUL_STAGES-1];
         base7_ff <= bd_ff[MUL_STAGES-1];
         for (int i = 0; i < 3; i++) begin
            case (rd_ff[MUL_STAGES-1])
               REG_FACE: begin
                  num7_ff[i] <= FN'(pf1_6[i]) + FN'(pf2_6[i]);
                  den7_ff[i] <= dd_ff[MUL_STAGES-1];
               end
               REG_AB, REG_AC, REG_BC: begin
                  num7_ff[i] <= FN'(pa6[i]);
                  den7_ff[i] <= dd_ff[MUL_STAGES-1];
               end
               default: begin
                  num7_ff[i] <= '0;
                  den7_ff[i] <= FD'(1);
               end
            endcase
         end
      end
   end

   assign num_out = num7_ff;
   assign den_out = den7_ff;
   assign base_out = base7_ff;
   assign region_out = reg7_ff;

endmodule

>>> design/cpt_div.sv
module cpt_div import cpt_pkg::*; #(
   parameter int W = COORD_BITS_DEF,
   parameter int NW = 8,
   parameter int DW = 4
) (
   input  logic clock,
   input  logic en,
   input  logic signed [NW-1:0] num,
   input  logic signed [DW-1:0] den,
   input  logic signed [W-1:0] base,
   output logic signed [W-1:0] res
);

   localparam int QB = W + 2;
   localparam int N2 = NW + 1;
   localparam int R = DW + 1;
   localparam int S = QB + 2;
   localparam logic signed [S-1:0] SAT_HI = S'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [S-1:0] SAT_LO = ~SAT_HI;

   logic [NW-1:0] an;
   logic [DW-1:0] ad;
   logic [N2-1:0] num2;
   logic [R-1:0] den2;
   logic [N2-QB-1:0] hi;
   logic ovf_in;

   always_comb begin
      an = num[NW-1] ? NW'(~num + 1'b1) : num;
      ad = den[DW-1] ? DW'(~den + 1'b1) : den;
      num2 = {an, 1'b0} + ad;
      den2 = {ad, 1'b0};
      hi = num2[N2-1:QB];
      ovf_in = (hi >= den2);
   end

   logic [R-1:0] rem_ff [QB+1];
   logic [QB-1:0] lo_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];
   logic [R-1:0] den_ff [QB+1];
   logic neg_ff [QB+1];
   logic ovf_ff [QB+1];
   logic signed [W-1:0] base_ff [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ovf_in ? '0 : R'(hi);
         lo_ff[0] <= num2[QB-1:0];
         q_ff[0] <= '0;
         den_ff[0] <= den2;
         neg_ff[0] <= num[NW-1] ^ den[DW-1];
         ovf_ff[0] <= ovf_in;
         base_ff[0] <= base;
      end
   end

   // one quotient bit per stage
   for (genvar s = 1; s <= QB; s++) begin : g_step
      logic [R:0] trial;
      logic ge;
      always_comb begin
         trial = {rem_ff[s-1], lo_ff[s-1][QB-1]};
         ge = (trial >= {1'b0, den_ff[s-1]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? R'(trial - {1'b0, den_ff[s-1]}) : R'(trial);
            lo_ff[s] <= {lo_ff[s-1][QB-2:0], 1'b0};
            q_ff[s] <= {q_ff[s-1][QB-2:0], ge};
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
            base_ff[s] <= base_ff[s-1];
         end
      end
   end

   logic signed [S-1:0] mag, sq, sum;
   logic signed [W-1:0] res_in;
   logic signed [W-1:0] res_ff;

   always_comb begin
      mag = $signed({2'b00, q_ff[QB]});
      sq = neg_ff[QB] ? -mag : mag;
      sum = sq + S'(base_ff[QB]);
      if (ovf_ff[QB]) begin
         res_in = neg_ff[QB] ? SAT_LO[W-1:0] : SAT_HI[W-1:0];
      end else if (sum > SAT_HI) begin
         res_in = SAT_HI[W-1:0];
      end else if (sum < SAT_LO) begin
         res_in = SAT_LO[W-1:0];
      end else begin
         res_in = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

>>> design/closest_point_on_triangle.sv
// channel  dir  payload                                   handshake
// req      in   point_x/y/z, vert_a/b/c_x/y/z             valid, ready
// rsp      out  near_x/y/z, region                        valid, ready
//
// one request enters per cycle unless a valid result is held at the output waiting for rsp.ready
// front: 15 stages, of which two five-stage multipliers for the cross and numerator products
// then COORD_BITS + 4 divider stages; one quotient bit per stage sets the depth
// reset clears only the valid bits of the pipeline
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
module closest_point_on_triangle import cpt_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   cpt_req_if.sink req,
   cpt_rsp_if.source rsp
);

   localparam int W = COORD_BITS;
   localparam int D = W + 1;
   localparam int K = 2 * D + 2;
   localparam int G = 2 * K + 1;
   localparam int FD = G + 2;
   localparam int FN = D + G + 2;
   localparam int DIV_LAT = W + 4;
   localparam int LAT = FRONT_LAT + DIV_LAT;

   logic en;
   logic [LAT-1:0] v_ff, v_in;

   logic signed [W-1:0] pt [3];
   logic signed [W-1:0] va [3];
   logic signed [W-1:0] vb [3];
   logic signed [W-1:0] vc [3];
   logic signed [FN-1:0] num_f [3];
   logic signed [FD-1:0] den_f [3];
   logic signed [W-1:0] base_f [3];
   logic signed [W-1:0] res [3];
   region_type region_f;
   region_type rg_ff [DIV_LAT];

   assign en = !v_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   assign pt[0] = req.point_x;
   assign pt[1] = req.point_y;
   assign pt[2] = req.point_z;
   assign va[0] = req.vert_a_x;
   assign va[1] = req.vert_a_y;
   assign va[2] = req.vert_a_z;
   assign vb[0] = req.vert_b_x;
   assign vb[1] = req.vert_b_y;
   assign vb[2] = req.vert_b_z;
   assign vc[0] = req.vert_c_x;
   assign vc[1] = req.vert_c_y;
   assign vc[2] = req.vert_c_z;

   cpt_front #(.W(W)) u_front (
      .clock      (clock),
      .en         (en),
      .pt         (pt),
      .va         (va),
      .vb         (vb),
      .vc         (vc),
      .num_out    (num_f),
      .den_out    (den_f),
      .base_out   (base_f),
      .region_out (region_f)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      cpt_div #(.W(W), .NW(FN), .DW(FD)) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_f[i]),
         .den   (den_f[i]),
         .base  (base_f[i]),
         .res   (res[i])
      );
   end

   always_comb begin
      v_in = {v_ff[LAT-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rg_ff[0] <= region_f;
         for (int s = 1; s < DIV_LAT; s++) begin
            rg_ff[s] <= rg_ff[s-1];
         end
      end
   end

   assign rsp.valid = v_ff[LAT-1];
   assign rsp.near_x = res[0];
   assign rsp.near_y = res[1];
   assign rsp.near_z = res[2];
   assign rsp.region = rg_ff[DIV_LAT-1];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> v_ff[0])
      else $error("accepted request not tracked");

endmodule
